// ===== sv/bpsr_pkg.sv =====
// bpsr_pkg: constants, types and register codes for the byte pattern search and replace core
// used by byte_pattern_search_replace_core; no other dependencies
package bpsr_pkg;

  // sizing
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int COUNT_BITS        = 24;
  localparam int PAT_BYTES         = 16;
  localparam int WIN_BYTES         = (MAX_PATTERN_BYTES < PAT_BYTES) ? MAX_PATTERN_BYTES
                                                                      : PAT_BYTES;
  localparam int FILL_W            = $clog2(WIN_BYTES + 1);
  localparam int CNT_OUT_W         = 24;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int IN_DATA_W         = 8;
  localparam int OUT_DATA_W        = 8 + CNT_OUT_W;

  // distance since the last match saturates at this value
  localparam logic [4:0] BSM_SAT = 5'd16;

  typedef logic [7:0]            byte_t;
  typedef logic [FILL_W-1:0]     fill_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEARCH_LO  = 3'd0,
    REG_SEARCH_HI  = 3'd1,
    REG_REPLACE_LO = 3'd2,
    REG_REPLACE_HI = 3'd3,
    REG_PAT_LEN    = 3'd4,
    REG_MAX_REPL   = 3'd5,
    REG_REPL_EN    = 3'd6
  } cfg_reg_t;

endpackage

// ===== sv/byte_pattern_search_replace_core.sv =====
// byte_pattern_search_replace_core: streaming byte pattern search, count and replace
// depends on bpsr_pkg for sizing constants, types and register codes
//
// output: a byte enters the output register as the item that pushes the window to the pattern
//   length is taken, once that register is free; the final item releases the rest of the window
// throughput: one item per cycle while results are accepted; after the final item the input
//   holds off while the window flushes, and while an owed result waits
// reset: rst_n synchronous, active low; clears window fill, counts and output valid, sets config defaults
module byte_pattern_search_replace_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input item stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bpsr_pkg::IN_DATA_W-1:0]       in_tdata,   // [7:0] data_byte
  input  logic                                 in_tlast,   // last_byte
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bpsr_pkg::OUT_DATA_W-1:0]      out_tdata,  // [7:0] out_byte, [31:8] match_count
  output logic                                 out_tlast,  // end_of_buffer
  output logic                                 out_tuser,  // was_replaced
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bpsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpsr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bpsr_pkg::*;

  // configuration registers
  byte_t       srch_r [PAT_BYTES];
  byte_t       repl_r [PAT_BYTES];
  logic [4:0]  pat_len_r;
  logic [15:0] max_repl_r;
  logic        repl_en_r;

  // window and buffer state
  byte_t  win_r   [WIN_BYTES];
  logic   mark_r  [WIN_BYTES];
  fill_t  fill_r;
  logic [4:0] bsm_r;
  count_t cnt_r;
  logic   lim_r;
  logic   drain_r;
  logic   over_r;

  byte_t  win_nxt  [WIN_BYTES];
  logic   mark_nxt [WIN_BYTES];
  fill_t  fill_nxt;
  logic [4:0] bsm_nxt;
  count_t cnt_nxt;
  logic   lim_nxt;
  logic   drain_nxt;
  logic   over_nxt;

  // output register
  logic                 out_vld_r, out_vld_nxt;
  byte_t                out_byte_r, out_byte_nxt;
  logic                 out_rep_r, out_rep_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  // step working values
  byte_t      win_s  [WIN_BYTES];
  logic       mark_s [WIN_BYTES];
  fill_t      fill_s;
  logic [4:0] bsm_s;
  count_t     cnt_s;
  logic       lim_s;
  logic       drain_s;
  fill_t      len;
  logic       step_en;
  logic       hit;
  logic       pop;
  logic       pop_end;
  logic       active;
  logic [31:0] cnt32;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !drain_r && !over_r;
  assign step_en    = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_cnt_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_rep_r;

  // effective pattern length, clamped to 1..window size
  always_comb begin
    if (pat_len_r == 5'd0) begin
      len = FILL_W'(1);
    end else if (32'(pat_len_r) > WIN_BYTES) begin
      len = FILL_W'(WIN_BYTES);
    end else begin
      len = FILL_W'(pat_len_r);
    end
  end

  // append, compare, replace, then release the window front
  always_comb begin
    win_s   = win_r;
    mark_s  = mark_r;
    fill_s  = fill_r;
    bsm_s   = bsm_r;
    cnt_s   = cnt_r;
    lim_s   = lim_r;
    drain_s = drain_r;
    hit     = 1'b0;

    if (step_en) begin
      for (int i = 0; i < WIN_BYTES; i++) begin
        if (FILL_W'(i) == fill_r) begin
          win_s[i]  = in_tdata[7:0];
          mark_s[i] = 1'b0;
        end
      end
      fill_s = fill_r + FILL_W'(1);
      if (bsm_r < BSM_SAT) begin
        bsm_s = bsm_r + 5'd1;
      end

      if (!lim_r && fill_s >= len && bsm_s >= 5'(len)) begin
        hit = 1'b1;
        for (int i = 0; i < WIN_BYTES; i++) begin
          if (FILL_W'(i) < len && win_s[i] != srch_r[i]) begin
            hit = 1'b0;
          end
        end
      end

      if (hit) begin
        if (cnt_r != '1) begin
          cnt_s = cnt_r + COUNT_BITS'(1);
        end
        if (repl_en_r) begin
          for (int i = 0; i < WIN_BYTES; i++) begin
            if (FILL_W'(i) < len) begin
              win_s[i]  = repl_r[i];
              mark_s[i] = 1'b1;
            end
          end
        end
        bsm_s = 5'd0;
        if (max_repl_r != 16'd0 && 32'(cnt_s) >= 32'(max_repl_r)) begin
          lim_s = 1'b1;
        end
      end

      if (in_tlast) begin
        drain_s = 1'b1;
      end
    end

    // results leave only when a step owes them
    active  = step_en || over_r || drain_r;
    pop     = active && (drain_s || fill_s >= len) && (fill_s != '0)
              && (!out_vld_r || out_tready);
    pop_end = pop && drain_s && (fill_s == FILL_W'(1));

    win_nxt   = win_s;
    mark_nxt  = mark_s;
    fill_nxt  = fill_s;
    bsm_nxt   = bsm_s;
    cnt_nxt   = cnt_s;
    lim_nxt   = lim_s;
    drain_nxt = drain_s;

    // saturate the count to the output width
    cnt32 = 32'(cnt_s);

    out_vld_nxt  = out_vld_r && !out_tready;
    out_byte_nxt = out_byte_r;
    out_rep_nxt  = out_rep_r;
    out_last_nxt = out_last_r;
    out_cnt_nxt  = out_cnt_r;

    if (pop) begin
      out_vld_nxt  = 1'b1;
      out_byte_nxt = win_s[0];
      out_rep_nxt  = mark_s[0];
      out_last_nxt = pop_end;
      if (pop_end) begin
        out_cnt_nxt = (cnt32 > 32'h00FF_FFFF) ? '1 : cnt32[CNT_OUT_W-1:0];
      end else begin
        out_cnt_nxt = '0;
      end
      for (int i = 0; i < WIN_BYTES - 1; i++) begin
        win_nxt[i]  = win_s[i+1];
        mark_nxt[i] = mark_s[i+1];
      end
      fill_nxt = fill_s - FILL_W'(1);
    end

    // end of buffer: back to the empty state
    if (pop_end) begin
      fill_nxt  = '0;
      bsm_nxt   = BSM_SAT;
      cnt_nxt   = '0;
      lim_nxt   = 1'b0;
      drain_nxt = 1'b0;
    end

    // results still owed by a non-final step
    over_nxt = (step_en || over_r) && !drain_nxt && (fill_nxt >= len) && (fill_nxt != '0);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      bsm_r     <= BSM_SAT;
      cnt_r     <= '0;
      lim_r     <= 1'b0;
      drain_r   <= 1'b0;
      over_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      bsm_r     <= bsm_nxt;
      cnt_r     <= cnt_nxt;
      lim_r     <= lim_nxt;
      drain_r   <= drain_nxt;
      over_r    <= over_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // window and result payload
  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    mark_r     <= mark_nxt;
    out_byte_r <= out_byte_nxt;
    out_rep_r  <= out_rep_nxt;
    out_last_r <= out_last_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAT_BYTES; i++) begin
        srch_r[i] <= '0;
        repl_r[i] <= '0;
      end
      pat_len_r  <= 5'd1;
      max_repl_r <= '0;
      repl_en_r  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEARCH_LO: begin
          for (int i = 0; i < 8; i++) srch_r[i] <= cfg_data[8*i +: 8];
        end
        REG_SEARCH_HI: begin
          for (int i = 0; i < 8; i++) srch_r[i+8] <= cfg_data[8*i +: 8];
        end
        REG_REPLACE_LO: begin
          for (int i = 0; i < 8; i++) repl_r[i] <= cfg_data[8*i +: 8];
        end
        REG_REPLACE_HI: begin
          for (int i = 0; i < 8; i++) repl_r[i+8] <= cfg_data[8*i +: 8];
        end
        REG_PAT_LEN:  pat_len_r  <= cfg_data[4:0];
        REG_MAX_REPL: max_repl_r <= cfg_data[15:0];
        REG_REPL_EN:  repl_en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
